// ===== hdl/deq_pkg.sv =====
// Shared types and constants for the double-ended queue.
// Request kind codes, status codes, port field widths and the pipeline record.
// No dependencies.
`default_nettype none

package deq_pkg;

   // port field widths
   localparam int KIND_W      = 3;
   localparam int VALUE_W     = 32;
   localparam int DATA_OUT_W  = 32;
   localparam int STATUS_W    = 2;
   localparam int COUNT_OUT_W = 5;
   localparam int REQ_TDATA_W = 32;
   localparam int RSP_TDATA_W = 40;

   // request kinds
   localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
   localparam logic [KIND_W-1:0] KIND_PUSH_REAR  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_POP_REAR   = 3'd3;
   localparam logic [KIND_W-1:0] KIND_PEEK_FRONT = 3'd4;
   localparam logic [KIND_W-1:0] KIND_PEEK_REAR  = 3'd5;

   // result status
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   // what travels alongside the memory read while it is in flight
   typedef struct packed {
      logic                   is_read;
      logic [STATUS_W-1:0]    status;
      logic [COUNT_OUT_W-1:0] count_after;
      logic                   is_empty;
   } meta_type;

endpackage

`default_nettype wire

// ===== hdl/deq_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// Used for the entry store of the queue. No dependencies.
`default_nettype none

module deq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // hold the last read word until the next read
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hdl/double_ended_queue.sv =====
// Bounded double-ended queue on a ring store held in one synchronous RAM.
// Depends on deq_pkg (codes, widths, pipeline record) and deq_ram.
//
//   channel  direction  ports                         item contents (low bits first)
//   req      in         req_tvalid/tready/tdata/tuser tdata: value; tuser: kind
//   rsp      out        rsp_tvalid/tready/tdata       tdata: data_out, status,
//                                                       count_after, is_empty
//
// One item per cycle sustained while rsp is ready; a result passes through the
// registered read of the entry RAM and then the output register.
// Head and count are updated at acceptance, so the next item sees them at once.
// Reset clears head, count and both valid flags; the RAM is not cleared, as only
// occupied slots are ever read.
// A stalled rsp holds the output register; the in-flight item then waits and
// req_tready drops until the output register frees.
`default_nettype none

module double_ended_queue #(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // request channel
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   input  wire logic [deq_pkg::REQ_TDATA_W-1:0]    req_tdata,  // [31:0] value
   input  wire logic [deq_pkg::KIND_W-1:0]         req_tuser,  // [2:0] kind
   // result channel
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   output logic      [deq_pkg::RSP_TDATA_W-1:0]    rsp_tdata   // [31:0] data_out,
                                                               // [33:32] status,
                                                               // [38:34] count_after,
                                                               // [39] is_empty
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   // ---------------------------------------------------------------- state
   logic [AW-1:0]            head_ff, head_in;
   logic [CW-1:0]            count_ff, count_in;
   logic                     s1_valid_ff, s1_valid_in;
   deq_pkg::meta_type        s1_meta_ff, s1_meta_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [deq_pkg::RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   // ---------------------------------------------------------------- RAM port
   logic                     wr_en, rd_en;
   logic [AW-1:0]            wr_addr, rd_addr;
   logic [DATA_WIDTH-1:0]    wr_data, rd_data;

   // ---------------------------------------------------------------- decode
   logic                     accept, s1_move;
   logic                     is_full, is_empty_now;
   logic [AW-1:0]            head_prev, head_next;
   logic [CW-1:0]            rear_offset;
   logic [AW:0]              rear_sum;
   logic [AW-1:0]            rear_slot;
   logic [deq_pkg::KIND_W-1:0] kind;

   assign kind         = req_tuser;
   assign is_full      = (count_ff == CW'(DEPTH));
   assign is_empty_now = (count_ff == '0);

   // advance s1 into the output register when that register frees this cycle
   assign s1_move    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_move;
   assign accept     = req_tvalid && req_tready;

   // neighbouring head slots, wrapping at DEPTH
   assign head_prev = (head_ff == '0) ? AW'(DEPTH - 1) : head_ff - 1'b1;
   assign head_next = (head_ff == AW'(DEPTH - 1)) ? '0 : head_ff + 1'b1;

   // rear slot: a push rear lands count places after head, the rear entry sits
   // count-1 places after it; the sum stays below twice DEPTH
   always_comb begin
      if (kind == deq_pkg::KIND_PUSH_REAR || is_empty_now) begin
         rear_offset = count_ff;
      end else begin
         rear_offset = count_ff - 1'b1;
      end
      rear_sum = (AW+1)'(head_ff) + (AW+1)'(rear_offset);
      if (rear_sum >= (AW+1)'(DEPTH)) begin
         rear_slot = AW'(rear_sum - (AW+1)'(DEPTH));
      end else begin
         rear_slot = AW'(rear_sum);
      end
   end

   // ---------------------------------------------------------------- step
   always_comb begin
      logic [deq_pkg::STATUS_W-1:0] status;
      logic                         is_read;
      logic                         do_wr;
      logic                         do_rd;

      status   = deq_pkg::STATUS_OK;
      is_read  = 1'b0;
      do_wr    = 1'b0;
      do_rd    = 1'b0;
      head_in  = head_ff;
      count_in = count_ff;
      wr_addr  = rear_slot;
      rd_addr  = rear_slot;

      case (kind)
         deq_pkg::KIND_PUSH_FRONT: begin
            if (is_full) begin
               status = deq_pkg::STATUS_FULL;
            end else begin
               do_wr    = 1'b1;
               wr_addr  = head_prev;
               head_in  = head_prev;
               count_in = count_ff + 1'b1;
            end
         end
         deq_pkg::KIND_PUSH_REAR: begin
            if (is_full) begin
               status = deq_pkg::STATUS_FULL;
            end else begin
               do_wr    = 1'b1;
               count_in = count_ff + 1'b1;
            end
         end
         deq_pkg::KIND_POP_FRONT, deq_pkg::KIND_PEEK_FRONT: begin
            if (is_empty_now) begin
               status = deq_pkg::STATUS_EMPTY;
            end else begin
               do_rd   = 1'b1;
               is_read = 1'b1;
               rd_addr = head_ff;
               if (kind == deq_pkg::KIND_POP_FRONT) begin
                  head_in  = head_next;
                  count_in = count_ff - 1'b1;
               end
            end
         end
         deq_pkg::KIND_POP_REAR, deq_pkg::KIND_PEEK_REAR: begin
            if (is_empty_now) begin
               status = deq_pkg::STATUS_EMPTY;
            end else begin
               do_rd   = 1'b1;
               is_read = 1'b1;
               if (kind == deq_pkg::KIND_POP_REAR) begin
                  count_in = count_ff - 1'b1;
               end
            end
         end
         default: begin
            // unused kinds leave the queue untouched
         end
      endcase

      // drop every effect unless the item is actually taken
      if (!accept) begin
         head_in  = head_ff;
         count_in = count_ff;
      end
      wr_en = accept && do_wr;
      rd_en = accept && do_rd;

      s1_meta_in.is_read     = is_read;
      s1_meta_in.status      = status;
      s1_meta_in.count_after = deq_pkg::COUNT_OUT_W'(count_in);
      s1_meta_in.is_empty    = (count_in == '0);
   end

   // keep the low DATA_WIDTH bits of the pushed word
   assign wr_data = DATA_WIDTH'(req_tdata);

   deq_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // ---------------------------------------------------------------- pipeline
   always_comb begin
      logic [deq_pkg::DATA_OUT_W-1:0] data_out;

      if (s1_meta_ff.is_read) begin
         data_out = deq_pkg::DATA_OUT_W'(rd_data);
      end else begin
         data_out = '0;
      end
      rsp_data_in = {s1_meta_ff.is_empty, s1_meta_ff.count_after,
                     s1_meta_ff.status, data_out};

      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end

      if (s1_move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         count_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         count_ff     <= count_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload: no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_meta_ff <= s1_meta_in;
      end
      if (s1_move) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ---------------------------------------------------------------- checks
`ifndef SYNTH
   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count beyond depth");

   a_full_push_ignored: assert property (@(posedge clock) disable iff (reset)
      (accept && is_full &&
       (kind == deq_pkg::KIND_PUSH_FRONT || kind == deq_pkg::KIND_PUSH_REAR))
      |=> (count_ff == $past(count_ff)) && (head_ff == $past(head_ff)))
      else $error("push onto a full queue changed state");

   a_pop_decrements: assert property (@(posedge clock) disable iff (reset)
      (accept && !is_empty_now &&
       (kind == deq_pkg::KIND_POP_FRONT || kind == deq_pkg::KIND_POP_REAR))
      |=> count_ff == CW'($past(count_ff) - 1'b1))
      else $error("pop did not remove one entry");

   a_s1_holds_on_stall: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_move) |=> s1_valid_ff && $stable(s1_meta_ff))
      else $error("in-flight item lost while output stalled");
`endif

endmodule

`default_nettype wire
